// ----- hdl/maze_explore_and_run_assert.svh -----
// Assertion macros used by the maze controller checker.
`ifndef MAZE_EXPLORE_AND_RUN_ASSERT_SVH
`define MAZE_EXPLORE_AND_RUN_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MER_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("maze controller check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("maze controller check failed");

`endif

// ----- hdl/mer_pkg.sv -----
// Shared types, constants and helper functions of the maze controller.
package mer_pkg;

   // Grid and store geometry.
   localparam int GRID_WIDTH          = 8;
   localparam int GRID_HEIGHT         = 8;
   localparam int CELLS               = GRID_WIDTH * GRID_HEIGHT;
   localparam int COORD_W             = 3;
   localparam int IDX_W               = 6;
   localparam int CELL_W              = 16;
   localparam int DIST_W              = 8;
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int MAX_PASSES          = 8;
   localparam int PASS_W              = $clog2(MAX_PASSES);

   // Cell word layout: walls in bits 0..3, marks, then the distance byte.
   localparam int WALL_N      = 0;
   localparam int WALL_E      = 1;
   localparam int WALL_S      = 2;
   localparam int WALL_W      = 3;
   localparam int BIT_VISITED = 4;
   localparam int BIT_DEAD    = 5;
   localparam int BIT_START   = 6;
   localparam int BIT_GOAL    = 7;
   localparam int DIST_LSB    = 8;

   // Absolute directions.
   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   // Move commands.
   localparam logic [2:0] MV_NONE     = 3'd0;
   localparam logic [2:0] MV_STRAIGHT = 3'd1;
   localparam logic [2:0] MV_LEFT     = 3'd2;
   localparam logic [2:0] MV_RIGHT    = 3'd3;
   localparam logic [2:0] MV_UTURN    = 3'd4;
   localparam logic [2:0] MV_FINISH   = 3'd5;

   // Junction codes with special handling.
   localparam logic [3:0] JN_START = 4'd7;
   localparam logic [3:0] JN_END   = 4'd8;

   typedef enum logic [2:0] {
      MODE_SEARCH,
      MODE_DEAD_END,
      MODE_BACKWARD,
      MODE_GOAL,
      MODE_RESTART
   } mode_type;

   // Outcome of one pass of the exploration mode machine.
   typedef enum logic [2:0] {
      ACT_CONT,
      ACT_ADV,
      ACT_BACK,
      ACT_FINISH,
      ACT_NONE
   } act_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_LOAD,
      ST_NB_E,
      ST_NB_S,
      ST_NB_W,
      ST_NB_END,
      ST_PASS,
      ST_WB,
      ST_POP,
      ST_POP_DONE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       rd_en;
      logic       rd_cur;
      logic [1:0] rd_dir;
      logic       cap_cur;
      logic       cap_nb;
      logic [1:0] cap_dir;
      logic       pass;
      logic       last_pass;
      logic       commit;
      logic       pop;
      logic       pop_done;
      logic       run;
      logic       emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic    func;
      act_type pass_act;
      act_type act;
      logic    out_busy;
   } status_type;

   // Walls seen relative to the heading: bit0 ahead, bit1 right, bit2 back, bit3 left.
   function automatic logic [3:0] rel_walls(input logic [3:0] junction);
      logic [3:0] m;
      unique case (junction)
         4'd0:    m = 4'hB;
         4'd1:    m = 4'hA;
         4'd2:    m = 4'h3;
         4'd3:    m = 4'h9;
         4'd4:    m = 4'h2;
         4'd5:    m = 4'h8;
         4'd6:    m = 4'h1;
         4'd7:    m = 4'hE;
         default: m = 4'h0;
      endcase
      return m;
   endfunction

   // Cell word after reset: outer walls, unknown distance, start cell at the origin.
   function automatic logic [CELL_W-1:0] cell_reset(input logic [IDX_W-1:0] idx);
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CELL_W-1:0]  c;
      x = COORD_W'(idx % GRID_WIDTH);
      y = COORD_W'(idx / GRID_WIDTH);
      c = {8'hFF, 8'h00};
      if (y == '0) c[WALL_S] = 1'b1;
      if (y == COORD_W'(GRID_HEIGHT - 1)) c[WALL_N] = 1'b1;
      if (x == '0) c[WALL_W] = 1'b1;
      if (x == COORD_W'(GRID_WIDTH - 1)) c[WALL_E] = 1'b1;
      if (idx == '0) begin
         c[BIT_START] = 1'b1;
         c[WALL_E]    = 1'b1;
         c[WALL_S]    = 1'b1;
         c[WALL_W]    = 1'b1;
      end
      return c;
   endfunction

endpackage

// ----- hdl/mer_ctrl.sv -----
// Sequencing state machine of the maze controller.
module mer_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mer_pkg::status_type status,
   output mer_pkg::cmd_type    cmd
);

   mer_pkg::state_type               state_ff, state_in;
   logic [mer_pkg::PASS_W-1:0]       pass_cnt_ff, pass_cnt_in;
   logic                             last_pass;

   assign req_stall = (state_ff != mer_pkg::ST_IDLE);
   assign last_pass = (pass_cnt_ff == mer_pkg::PASS_W'(mer_pkg::MAX_PASSES - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mer_pkg::ST_IDLE:     if (req_valid) state_in = mer_pkg::ST_RD_CUR;
         mer_pkg::ST_RD_CUR:   state_in = mer_pkg::ST_LOAD;
         mer_pkg::ST_LOAD:     state_in = mer_pkg::ST_NB_E;
         mer_pkg::ST_NB_E:     state_in = mer_pkg::ST_NB_S;
         mer_pkg::ST_NB_S:     state_in = mer_pkg::ST_NB_W;
         mer_pkg::ST_NB_W:     state_in = mer_pkg::ST_NB_END;
         mer_pkg::ST_NB_END: begin
            state_in = status.func ? mer_pkg::ST_RUN : mer_pkg::ST_PASS;
         end
         mer_pkg::ST_PASS: begin
            if (status.pass_act != mer_pkg::ACT_CONT || last_pass) state_in = mer_pkg::ST_WB;
         end
         mer_pkg::ST_WB: begin
            state_in = (status.act == mer_pkg::ACT_BACK) ? mer_pkg::ST_POP : mer_pkg::ST_DONE;
         end
         mer_pkg::ST_POP:      state_in = mer_pkg::ST_POP_DONE;
         mer_pkg::ST_POP_DONE: state_in = mer_pkg::ST_DONE;
         mer_pkg::ST_RUN:      state_in = mer_pkg::ST_DONE;
         mer_pkg::ST_DONE:     if (!status.out_busy) state_in = mer_pkg::ST_IDLE;
         default:              state_in = mer_pkg::ST_IDLE;
      endcase
   end

   // Pass counter for the bounded mode machine loop.
   always_comb begin
      pass_cnt_in = pass_cnt_ff;
      if (state_ff == mer_pkg::ST_NB_END) pass_cnt_in = '0;
      else if (state_ff == mer_pkg::ST_PASS) pass_cnt_in = pass_cnt_ff + 1'b1;
   end

   // Command outputs.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         mer_pkg::ST_IDLE:   cmd.accept = req_valid;
         mer_pkg::ST_RD_CUR: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_cur = 1'b1;
         end
         mer_pkg::ST_LOAD: begin
            cmd.cap_cur = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_dir  = mer_pkg::DIR_N;
         end
         mer_pkg::ST_NB_E: begin
            cmd.cap_nb  = 1'b1;
            cmd.cap_dir = mer_pkg::DIR_N;
            cmd.rd_en   = 1'b1;
            cmd.rd_dir  = mer_pkg::DIR_E;
         end
         mer_pkg::ST_NB_S: begin
            cmd.cap_nb  = 1'b1;
            cmd.cap_dir = mer_pkg::DIR_E;
            cmd.rd_en   = 1'b1;
            cmd.rd_dir  = mer_pkg::DIR_S;
         end
         mer_pkg::ST_NB_W: begin
            cmd.cap_nb  = 1'b1;
            cmd.cap_dir = mer_pkg::DIR_S;
            cmd.rd_en   = 1'b1;
            cmd.rd_dir  = mer_pkg::DIR_W;
         end
         mer_pkg::ST_NB_END: begin
            cmd.cap_nb  = 1'b1;
            cmd.cap_dir = mer_pkg::DIR_W;
         end
         mer_pkg::ST_PASS: begin
            cmd.pass      = 1'b1;
            cmd.last_pass = last_pass;
         end
         mer_pkg::ST_WB:       cmd.commit   = 1'b1;
         mer_pkg::ST_POP:      cmd.pop      = 1'b1;
         mer_pkg::ST_POP_DONE: cmd.pop_done = 1'b1;
         mer_pkg::ST_RUN:      cmd.run      = 1'b1;
         mer_pkg::ST_DONE:     cmd.emit     = !status.out_busy;
         default:              cmd          = '0;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mer_pkg::ST_IDLE;
         pass_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         pass_cnt_ff <= pass_cnt_in;
      end
   end

endmodule

// ----- hdl/mer_datapath.sv -----
// Datapath of the maze controller: cell store, path stack, robot state and result register.
module mer_datapath #(
   parameter int STACK_DEPTH = mer_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  mer_pkg::cmd_type    cmd,
   output mer_pkg::status_type status,
   input  logic                req_func,
   input  logic [3:0]          req_junction,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_move,
   output logic [2:0]          rsp_pos_x,
   output logic [2:0]          rsp_pos_y,
   output logic [1:0]          rsp_heading_out,
   output logic signed [6:0]   rsp_step_distance,
   output logic                rsp_stack_fault
);

   localparam int CW    = mer_pkg::COORD_W;
   localparam int IW    = mer_pkg::IDX_W;
   localparam int WW    = mer_pkg::CELL_W;
   localparam int DW    = mer_pkg::DIST_W;
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int LVL_W = $clog2(STACK_DEPTH + 1);

   // Step input and robot state.
   logic                 func_ff;
   logic [3:0]           junction_ff;
   logic [CW-1:0]        x_ff, y_ff;
   logic [1:0]           heading_ff;
   logic [DW-1:0]        pc_ff;
   mer_pkg::mode_type    mode_ff;
   logic                 goal_seen_ff, branch_active_ff;
   logic [DW-1:0]        branch_depth_ff;
   logic [LVL_W-1:0]     level_ff;
   logic                 fault_ff;
   logic [2:0]           move_ff;
   mer_pkg::act_type     act_ff;
   logic [1:0]           dir_ff;

   // Working copy of the current cell and captured neighbor fields.
   logic [WW-1:0]        cur_ff;
   logic [3:0]           nb_vis_ff, nb_dead_ff;
   logic [DW-1:0]        nb_dist_ff [4];

   // Cell store with per-entry valid bits, and the path stack.
   logic [WW-1:0]        cell_mem [mer_pkg::CELLS];
   logic [mer_pkg::CELLS-1:0] cell_valid_ff;
   logic [WW-1:0]        rd_data_ff;
   logic                 rd_valid_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic [IW-1:0]        stack_mem [STACK_DEPTH];
   logic [IW-1:0]        stk_rd_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_move_ff;
   logic [CW-1:0]        rsp_x_ff, rsp_y_ff;
   logic [1:0]           rsp_heading_ff;
   logic [6:0]           rsp_dist_ff;
   logic                 rsp_fault_ff;

   // Combinational helpers.
   logic [IW-1:0]        cur_idx;
   logic [CW-1:0]        nb_x [4];
   logic [CW-1:0]        nb_y [4];
   logic [3:0]           nb_in;
   logic [IW-1:0]        nb_idx [4];
   logic [IW-1:0]        rd_addr;
   logic [WW-1:0]        rd_word, rec_word;
   logic [3:0]           rec_mask;
   logic [3:0]           cand;
   logic [1:0]           dir_ahead, dir_right, dir_left;

   logic [WW-1:0]        p_cur;
   mer_pkg::act_type     p_act;
   mer_pkg::mode_type    p_mode;
   logic                 p_goal_seen, p_branch_active;
   logic [DW-1:0]        p_branch_depth;
   logic [1:0]           p_heading, p_dir;

   logic [DW-1:0]        pc_inc;
   logic [3:0]           run_match;
   logic                 run_found;
   logic [1:0]           run_dir;

   logic [CW-1:0]        go_x, go_y;
   logic                 go_up, go_dn, go_rt, go_lf, go_ok;
   logic [1:0]           go_nh, go_diff;
   logic [2:0]           go_mv;

   assign cur_idx = IW'(int'(y_ff) * mer_pkg::GRID_WIDTH + int'(x_ff));

   // Neighbor coordinates and grid membership per absolute direction.
   always_comb begin
      nb_x[mer_pkg::DIR_N] = x_ff;
      nb_y[mer_pkg::DIR_N] = y_ff + 1'b1;
      nb_x[mer_pkg::DIR_E] = x_ff + 1'b1;
      nb_y[mer_pkg::DIR_E] = y_ff;
      nb_x[mer_pkg::DIR_S] = x_ff;
      nb_y[mer_pkg::DIR_S] = y_ff - 1'b1;
      nb_x[mer_pkg::DIR_W] = x_ff - 1'b1;
      nb_y[mer_pkg::DIR_W] = y_ff;
      nb_in[mer_pkg::DIR_N] = (y_ff != CW'(mer_pkg::GRID_HEIGHT - 1));
      nb_in[mer_pkg::DIR_E] = (x_ff != CW'(mer_pkg::GRID_WIDTH - 1));
      nb_in[mer_pkg::DIR_S] = (y_ff != '0);
      nb_in[mer_pkg::DIR_W] = (x_ff != '0);
      for (int d = 0; d < 4; d++) begin
         nb_idx[d] = IW'(int'(nb_y[d]) * mer_pkg::GRID_WIDTH + int'(nb_x[d]));
      end
   end

   assign rd_addr = cmd.rd_cur ? cur_idx : nb_idx[cmd.rd_dir];
   assign rd_word = rd_valid_ff ? rd_data_ff : mer_pkg::cell_reset(rd_idx_ff);

   // Record the current cell: goal mark, walls on first visit, visited and distance.
   always_comb begin
      rec_word = rd_word;
      rec_mask = mer_pkg::rel_walls(junction_ff);
      if (junction_ff == mer_pkg::JN_START && heading_ff != mer_pkg::DIR_N) rec_mask = '0;
      if (junction_ff == mer_pkg::JN_END) rec_word[mer_pkg::BIT_GOAL] = 1'b1;
      if (!rd_word[mer_pkg::BIT_VISITED]) begin
         for (int r = 0; r < 4; r++) begin
            if (rec_mask[r]) rec_word[2'(heading_ff + 2'(r))] = 1'b1;
         end
      end
      rec_word[mer_pkg::BIT_VISITED] = 1'b1;
      rec_word[WW-1:mer_pkg::DIST_LSB] = pc_ff;
   end

   // Open, in-grid, unvisited neighbors.
   always_comb begin
      for (int d = 0; d < 4; d++) begin
         cand[d] = !cur_ff[d] && nb_in[d] && !nb_vis_ff[d];
      end
   end

   assign dir_ahead = heading_ff;
   assign dir_right = heading_ff + 2'd1;
   assign dir_left  = heading_ff + 2'd3;

   // One pass of the exploration mode machine.
   always_comb begin
      p_cur           = cur_ff;
      p_act           = mer_pkg::ACT_CONT;
      p_mode          = mode_ff;
      p_goal_seen     = goal_seen_ff;
      p_branch_active = branch_active_ff;
      p_branch_depth  = branch_depth_ff;
      p_heading       = heading_ff;
      p_dir           = dir_ff;
      case (mode_ff)
         mer_pkg::MODE_DEAD_END: begin
            p_cur[mer_pkg::BIT_DEAD] = 1'b1;
            p_mode = mer_pkg::MODE_BACKWARD;
            p_act  = mer_pkg::ACT_BACK;
         end
         mer_pkg::MODE_BACKWARD: begin
            if (cur_ff[mer_pkg::BIT_START]) begin
               p_mode    = mer_pkg::MODE_RESTART;
               p_heading = mer_pkg::DIR_N;
               p_act     = mer_pkg::ACT_FINISH;
            end else if (cand[dir_ahead] || cand[dir_right] || cand[dir_left]) begin
               p_mode = mer_pkg::MODE_SEARCH;
               if (goal_seen_ff) begin
                  p_branch_active = 1'b1;
                  p_branch_depth  = pc_ff;
               end
            end else begin
               if (!goal_seen_ff) begin
                  p_cur[mer_pkg::BIT_DEAD] = 1'b1;
               end else if (branch_active_ff && ($signed({1'b0, pc_ff}) >
                            $signed({branch_depth_ff[DW-1], branch_depth_ff}))) begin
                  p_cur[mer_pkg::BIT_DEAD] = 1'b1;
               end else begin
                  p_branch_active = 1'b0;
               end
               p_act = mer_pkg::ACT_BACK;
            end
         end
         mer_pkg::MODE_GOAL: begin
            p_goal_seen     = 1'b1;
            p_branch_active = 1'b0;
            p_mode          = mer_pkg::MODE_BACKWARD;
         end
         mer_pkg::MODE_RESTART: p_act = mer_pkg::ACT_FINISH;
         default: begin
            p_cur[mer_pkg::BIT_VISITED] = 1'b1;
            if (cur_ff[mer_pkg::BIT_GOAL]) begin
               p_mode = mer_pkg::MODE_GOAL;
            end else if (cand[dir_ahead]) begin
               p_dir  = dir_ahead;
               p_mode = mer_pkg::MODE_SEARCH;
               p_act  = mer_pkg::ACT_ADV;
            end else if (cand[dir_right]) begin
               p_dir  = dir_right;
               p_mode = mer_pkg::MODE_SEARCH;
               p_act  = mer_pkg::ACT_ADV;
            end else if (cand[dir_left]) begin
               p_dir  = dir_left;
               p_mode = mer_pkg::MODE_SEARCH;
               p_act  = mer_pkg::ACT_ADV;
            end else begin
               p_mode = mer_pkg::MODE_DEAD_END;
            end
         end
      endcase
   end

   // Run step: first neighbor in the order north, south, east, west one step further on.
   assign pc_inc = pc_ff + 1'b1;
   always_comb begin
      for (int d = 0; d < 4; d++) begin
         run_match[d] = nb_in[d] && (nb_dist_ff[d] == pc_inc) && !pc_inc[DW-1] &&
                        !nb_dead_ff[d];
      end
      run_found = 1'b1;
      if (run_match[mer_pkg::DIR_N]) run_dir = mer_pkg::DIR_N;
      else if (run_match[mer_pkg::DIR_S]) run_dir = mer_pkg::DIR_S;
      else if (run_match[mer_pkg::DIR_E]) run_dir = mer_pkg::DIR_E;
      else if (run_match[mer_pkg::DIR_W]) run_dir = mer_pkg::DIR_W;
      else begin
         run_dir   = mer_pkg::DIR_N;
         run_found = 1'b0;
      end
   end

   // Move toward a destination cell: new heading and turn command.
   always_comb begin
      if (cmd.pop_done) begin
         go_x = fault_ff ? x_ff : CW'(stk_rd_ff % mer_pkg::GRID_WIDTH);
         go_y = fault_ff ? y_ff : CW'(stk_rd_ff / mer_pkg::GRID_WIDTH);
      end else if (cmd.run) begin
         // The start cell always heads north on a run step.
         go_x = cur_ff[mer_pkg::BIT_START] ? nb_x[mer_pkg::DIR_N] : nb_x[run_dir];
         go_y = cur_ff[mer_pkg::BIT_START] ? nb_y[mer_pkg::DIR_N] : nb_y[run_dir];
      end else begin
         go_x = nb_x[dir_ff];
         go_y = nb_y[dir_ff];
      end
      go_up = (({1'b0, y_ff} + 1'b1) == {1'b0, go_y});
      go_dn = (({1'b0, go_y} + 1'b1) == {1'b0, y_ff});
      go_rt = (({1'b0, x_ff} + 1'b1) == {1'b0, go_x});
      go_lf = (({1'b0, go_x} + 1'b1) == {1'b0, x_ff});
      go_ok = go_up || go_dn || go_rt || go_lf;
      if (go_up) go_nh = mer_pkg::DIR_N;
      else if (go_dn) go_nh = mer_pkg::DIR_S;
      else if (go_rt) go_nh = mer_pkg::DIR_E;
      else go_nh = mer_pkg::DIR_W;
      go_diff = go_nh - heading_ff;
      case (go_diff)
         2'd0:    go_mv = mer_pkg::MV_STRAIGHT;
         2'd1:    go_mv = mer_pkg::MV_RIGHT;
         2'd2:    go_mv = mer_pkg::MV_UTURN;
         default: go_mv = mer_pkg::MV_LEFT;
      endcase
      if (!go_ok) go_mv = mer_pkg::MV_NONE;
   end

   // Cell store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.commit) cell_mem[cur_idx] <= cur_ff;
      if (cmd.rd_en) begin
         rd_data_ff  <= cell_mem[rd_addr];
         rd_valid_ff <= cell_valid_ff[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
   end

   // Valid bits: an entry never written reads as its reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= '0;
      end else if (cmd.commit) begin
         cell_valid_ff[cur_idx] <= 1'b1;
      end
   end

   // Path stack: push on advance, registered read on pop.
   always_ff @(posedge clock) begin
      if (cmd.commit && act_ff == mer_pkg::ACT_ADV && level_ff < LVL_W'(STACK_DEPTH)) begin
         stack_mem[level_ff[SA_W-1:0]] <= cur_idx;
      end
      if (cmd.pop) stk_rd_ff <= stack_mem[SA_W'(level_ff - 1'b1)];
   end

   // Step input, working cell and neighbor captures.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff     <= req_func;
         junction_ff <= req_junction;
      end
      if (cmd.cap_cur) cur_ff <= func_ff ? rd_word : rec_word;
      else if (cmd.pass) cur_ff <= p_cur;
      if (cmd.cap_nb) begin
         nb_vis_ff[cmd.cap_dir]  <= rd_word[mer_pkg::BIT_VISITED];
         nb_dead_ff[cmd.cap_dir] <= rd_word[mer_pkg::BIT_DEAD];
         nb_dist_ff[cmd.cap_dir] <= rd_word[WW-1:mer_pkg::DIST_LSB];
      end
      if (cmd.pass) begin
         act_ff <= (p_act == mer_pkg::ACT_CONT && cmd.last_pass) ? mer_pkg::ACT_NONE : p_act;
         dir_ff <= p_dir;
      end
   end

   // Robot state and exploration bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff             <= '0;
         y_ff             <= '0;
         heading_ff       <= mer_pkg::DIR_N;
         pc_ff            <= '0;
         mode_ff          <= mer_pkg::MODE_SEARCH;
         goal_seen_ff     <= 1'b0;
         branch_active_ff <= 1'b0;
         branch_depth_ff  <= '0;
         level_ff         <= '0;
         fault_ff         <= 1'b0;
         move_ff          <= mer_pkg::MV_NONE;
      end else begin
         if (cmd.accept) begin
            fault_ff <= 1'b0;
            move_ff  <= mer_pkg::MV_NONE;
         end
         if (cmd.pass) begin
            mode_ff          <= p_mode;
            goal_seen_ff     <= p_goal_seen;
            branch_active_ff <= p_branch_active;
            branch_depth_ff  <= p_branch_depth;
            heading_ff       <= p_heading;
         end
         if (cmd.commit) begin
            case (act_ff)
               mer_pkg::ACT_ADV: begin
                  pc_ff <= pc_inc;
                  if (level_ff < LVL_W'(STACK_DEPTH)) level_ff <= level_ff + 1'b1;
                  else fault_ff <= 1'b1;
                  x_ff <= go_x;
                  y_ff <= go_y;
                  if (go_ok) heading_ff <= go_nh;
                  move_ff <= go_mv;
               end
               mer_pkg::ACT_FINISH: move_ff <= mer_pkg::MV_FINISH;
               default:             move_ff <= mer_pkg::MV_NONE;
            endcase
         end
         if (cmd.pop) begin
            pc_ff <= pc_ff - 1'b1;
            if (level_ff == '0) fault_ff <= 1'b1;
            else level_ff <= level_ff - 1'b1;
         end
         if (cmd.pop_done) begin
            x_ff <= go_x;
            y_ff <= go_y;
            if (go_ok) heading_ff <= go_nh;
            move_ff <= go_mv;
         end
         if (cmd.run) begin
            pc_ff <= pc_inc;
            if (cur_ff[mer_pkg::BIT_START]) begin
               if (nb_in[mer_pkg::DIR_N]) begin
                  x_ff       <= go_x;
                  y_ff       <= go_y;
                  heading_ff <= go_nh;
                  move_ff    <= go_mv;
               end else begin
                  move_ff <= mer_pkg::MV_NONE;
               end
            end else if (cur_ff[mer_pkg::BIT_GOAL]) begin
               move_ff <= mer_pkg::MV_FINISH;
            end else if (run_found) begin
               x_ff       <= go_x;
               y_ff       <= go_y;
               heading_ff <= go_nh;
               move_ff    <= go_mv;
            end else begin
               move_ff <= mer_pkg::MV_NONE;
            end
         end
      end
   end

   // Result register: holds a finished transfer while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_move_ff    <= move_ff;
         rsp_x_ff       <= x_ff;
         rsp_y_ff       <= y_ff;
         rsp_heading_ff <= heading_ff;
         rsp_dist_ff    <= pc_ff[6:0];
         rsp_fault_ff   <= fault_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_move          = rsp_move_ff;
   assign rsp_pos_x         = rsp_x_ff;
   assign rsp_pos_y         = rsp_y_ff;
   assign rsp_heading_out   = rsp_heading_ff;
   assign rsp_step_distance = $signed(rsp_dist_ff);
   assign rsp_stack_fault   = rsp_fault_ff;

   assign status.func     = func_ff;
   assign status.pass_act = p_act;
   assign status.act      = act_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

endmodule

// ----- hdl/maze_explore_and_run.sv -----
// Run step: read the current cell and its four neighbors, then one run step. Explore step:
// the same reads, then the mode machine, one pass per cycle (at most eight passes), then,
// on a back move, a pop through the path stack's registered read port.
// One step at a time: the next request is taken once the result is in the output register.
// Synchronous active-high reset returns the robot to the start cell heading north and
// clears the cell store's valid bits; cells then read as their reset value.
module maze_explore_and_run #(
   parameter int STACK_DEPTH = mer_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [3:0]        req_junction,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_move,
   output logic [2:0]        rsp_pos_x,
   output logic [2:0]        rsp_pos_y,
   output logic [1:0]        rsp_heading_out,
   output logic signed [6:0] rsp_step_distance,
   output logic              rsp_stack_fault
);

   mer_pkg::cmd_type    cmd;
   mer_pkg::status_type status;

   // Step sequencer.
   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Stores, robot state and output register.
   mer_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_junction      (req_junction),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_move          (rsp_move),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_heading_out   (rsp_heading_out),
      .rsp_step_distance (rsp_step_distance),
      .rsp_stack_fault   (rsp_stack_fault)
   );

endmodule

// ----- hdl/mer_checker.sv -----
// Port-level checks of the maze controller and their attachment to the top level.
`include "maze_explore_and_run_assert.svh"

module mer_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_func,
   input logic [3:0]        req_junction,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_move,
   input logic [2:0]        rsp_pos_x,
   input logic [2:0]        rsp_pos_y,
   input logic [1:0]        rsp_heading_out,
   input logic signed [6:0] rsp_step_distance,
   input logic              rsp_stack_fault
);

   logic [4:0]  req_word;
   logic [18:0] rsp_word;

   // Whole payloads of both channels.
   assign req_word = {req_func, req_junction};
   assign rsp_word = {rsp_move, rsp_pos_x, rsp_pos_y, rsp_heading_out, rsp_step_distance,
                      rsp_stack_fault};

   // A stalled result holds every field.
   `MER_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // A stalled request holds its payload.
   `MER_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_word))

   // Move commands stay within the defined set.
   `MER_ASSERT_NOW(a_move_code, clock, reset, rsp_valid, rsp_move <= mer_pkg::MV_FINISH)

   // After an input transfer the block is busy with that step.
   `MER_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // A new result only ever follows a step in progress.
   `MER_ASSERT_NOW(a_rsp_from_step, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind maze_explore_and_run mer_checker u_mer_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_func          (req_func),
   .req_junction      (req_junction),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_move          (rsp_move),
   .rsp_pos_x         (rsp_pos_x),
   .rsp_pos_y         (rsp_pos_y),
   .rsp_heading_out   (rsp_heading_out),
   .rsp_step_distance (rsp_step_distance),
   .rsp_stack_fault   (rsp_stack_fault)
);
